FILE: hdl/dds_pkg.sv
// Shared types and constants for the domain decimate statistics block.
// Used by dds_alu and domain_decimate_statistics; depends on nothing.

package dds_pkg;

    localparam int SAMPLE_W = 16;   // input sample
    localparam int PAIR_W   = 17;   // pair value, Q.1
    localparam int INDEX_W  = 12;   // forward / backward index
    localparam int LEN_W    = 13;   // range length register
    localparam int SUM_W    = 30;   // running sum, Q.1
    localparam int MAG_W    = 29;   // magnitude of the running sum
    localparam int SQ_W     = 45;   // running sum of squares
    localparam int BETA_W   = 57;   // beta, Q.2
    localparam int ACC_W    = 57;   // shared adder and accumulator
    localparam int MPL_W    = 29;   // multiplier / dividend shift register
    localparam int CNT_W    = 5;    // step counter
    localparam int REM_W    = 14;   // shifted partial remainder

    localparam logic [LEN_W-1:0] LEN_RESET = 13'd64;
    localparam logic [LEN_W-1:0] MAX_PAIRS = 13'd4096;

    // Steps per operation, counted down to zero
    localparam logic [CNT_W-1:0] SQ_STEPS  = 5'd17;   // pair magnitude bits
    localparam logic [CNT_W-1:0] NSQ_STEPS = 5'd13;   // bits of N
    localparam logic [CNT_W-1:0] SSQ_STEPS = 5'd29;   // bits of |sum|
    localparam logic [CNT_W-1:0] DIV_STEPS = 5'd29;   // quotient bits

    typedef struct packed {
        logic             carry;
        logic [ACC_W-1:0] value;
    } alu_res_t;

endpackage

FILE: hdl/domain_decimate_statistics.sv
// Top level of the domain decimate statistics block: sequencer, state and output register.
// Depends on dds_pkg and dds_alu.
//
//  channel  | handshake             | word
//  ---------+-----------------------+------------------------------------------------
//  cfg      | cfg_valid, cfg_ready  | range_length
//  in       | in_valid, in_ready    | sample
//  out      | out_valid, out_ready  | pair_value, forward_index, backward_index,
//           |                       | domain_done, domain_sum, domain_average,
//           |                       | domain_beta
//
//  The first sample of a pair is held. The second starts the square step: the
//  square of the pair value is added into the sum of squares one multiplier bit
//  per cycle (17 steps) on the shared 57-bit adder. The final pair of a domain
//  adds 13 steps for N times the sum of squares, 29 for sum squared, 1 for the
//  beta subtract and 29 for the restoring divide.
//  A finished result holds in the output register until taken; a stalled output
//  holds the sequencer in its last step, and in_ready stays low meanwhile.
//  Reset clears the domain state and loads range_length with 64; cfg is always ready.

module domain_decimate_statistics (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dds_pkg::LEN_W-1:0]           range_length,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [dds_pkg::SAMPLE_W-1:0] sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [dds_pkg::PAIR_W-1:0]   pair_value,
    output logic [dds_pkg::INDEX_W-1:0]         forward_index,
    output logic [dds_pkg::INDEX_W-1:0]         backward_index,
    output logic                                domain_done,
    output logic signed [dds_pkg::SUM_W-1:0]    domain_sum,
    output logic signed [dds_pkg::PAIR_W-1:0]   domain_average,
    output logic [dds_pkg::BETA_W-1:0]          domain_beta
);
    import dds_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;   // wait for a sample
    localparam logic [2:0] S_SQ   = 3'd1;   // sum of squares += v^2
    localparam logic [2:0] S_NSQ  = 3'd2;   // N * sum of squares
    localparam logic [2:0] S_SSQ  = 3'd3;   // sum * sum
    localparam logic [2:0] S_BETA = 3'd4;   // N*sq - sum^2, clamp at zero
    localparam logic [2:0] S_DIV  = 3'd5;   // |sum| / N, restoring
    localparam logic [2:0] S_FIN  = 3'd6;   // load output register

    // Control and domain state
    logic [2:0]          state_reg, state_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [SAMPLE_W-1:0] held_reg, held_next;
    logic                phase_reg, phase_next;
    logic [INDEX_W-1:0]  pos_reg, pos_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic                out_valid_reg, out_valid_next;

    // Iteration datapath
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ACC_W-1:0]    mcand_reg, mcand_next;
    logic [MPL_W-1:0]    mpl_reg, mpl_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ACC_W-1:0]    nsq_reg, nsq_next;
    logic [BETA_W-1:0]   beta_reg, beta_next;

    // Captured pair
    logic [LEN_W-1:0]    n_reg, n_next;
    logic [PAIR_W-1:0]   pair_reg, pair_next;
    logic [INDEX_W-1:0]  fwd_reg, fwd_next;
    logic [INDEX_W-1:0]  bwd_reg, bwd_next;
    logic                done_reg, done_next;

    // Output register
    logic [PAIR_W-1:0]   o_pair_reg, o_pair_next;
    logic [INDEX_W-1:0]  o_fwd_reg, o_fwd_next;
    logic [INDEX_W-1:0]  o_bwd_reg, o_bwd_next;
    logic                o_done_reg, o_done_next;
    logic [SUM_W-1:0]    o_sum_reg, o_sum_next;
    logic [PAIR_W-1:0]   o_avg_reg, o_avg_next;
    logic [BETA_W-1:0]   o_beta_reg, o_beta_next;

    // Combinational helpers
    logic [LEN_W-1:0]    eff_n;
    logic [PAIR_W-1:0]   pair_val;
    logic [PAIR_W-1:0]   pair_mag;
    logic [LEN_W-1:0]    pos_plus;
    logic [LEN_W-1:0]    bwd_full;
    logic                last_pair;
    logic [SUM_W-1:0]    sum_neg;
    logic [MAG_W-1:0]    sum_mag;
    logic [REM_W-1:0]    rem_sh;
    logic [PAIR_W-1:0]   quot;
    logic [PAIR_W-1:0]   avg_val;
    logic                in_fire;
    logic                out_free;
    logic [ACC_W-1:0]    alu_a, alu_b;
    logic                alu_sub;
    alu_res_t            alu_res;
    logic [ACC_W-1:0]    acc_step;

    dds_alu u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .sub  (alu_sub),
        .res  (alu_res)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Clamp N to 1..MAX_PAIRS
    always_comb
    begin
        priority if (len_reg == '0)
            eff_n = {{(LEN_W-1){1'b0}}, 1'b1};
        else if (len_reg > MAX_PAIRS)
            eff_n = MAX_PAIRS;
        else
            eff_n = len_reg;
    end

    // Pair value is the plain sum of the two samples (mean in Q.1)
    assign pair_val  = {held_reg[SAMPLE_W-1], held_reg} + {sample[SAMPLE_W-1], sample};
    assign pair_mag  = pair_val[PAIR_W-1] ? (~pair_val + {{(PAIR_W-1){1'b0}}, 1'b1})
                                          : pair_val;
    assign pos_plus  = {1'b0, pos_reg} + {{(LEN_W-1){1'b0}}, 1'b1};
    assign last_pair = (pos_plus >= eff_n);
    assign bwd_full  = eff_n - pos_plus;

    assign sum_neg   = ~sum_reg + {{(SUM_W-1){1'b0}}, 1'b1};
    assign sum_mag   = sum_reg[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_reg[MAG_W-1:0];

    // Remainder stays below N, so its low bits carry it
    assign rem_sh    = {acc_reg[REM_W-2:0], mpl_reg[MPL_W-1]};

    // Quotient of |sum| / N; negate for a negative sum, keep the low bits
    assign quot      = mpl_reg[PAIR_W-1:0];
    assign avg_val   = sum_reg[SUM_W-1] ? (~quot + {{(PAIR_W-1){1'b0}}, 1'b1}) : quot;

    // Operand select for the shared adder
    always_comb
    begin
        unique case (state_reg)
            S_BETA:
            begin
                alu_a   = nsq_reg;
                alu_b   = acc_reg;
                alu_sub = 1'b1;
            end
            S_DIV:
            begin
                alu_a   = {{(ACC_W-REM_W){1'b0}}, rem_sh};
                alu_b   = {{(ACC_W-LEN_W){1'b0}}, n_reg};
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = acc_reg;
                alu_b   = mcand_reg;
                alu_sub = 1'b0;
            end
        endcase
    end

    // One shift-add step: add only where the multiplier bit is set
    assign acc_step = mpl_reg[0] ? alu_res.value : acc_reg;

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        held_next      = held_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        sq_next        = sq_reg;
        out_valid_next = out_valid_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mpl_next       = mpl_reg;
        cnt_next       = cnt_reg;
        nsq_next       = nsq_reg;
        beta_next      = beta_reg;
        n_next         = n_reg;
        pair_next      = pair_reg;
        fwd_next       = fwd_reg;
        bwd_next       = bwd_reg;
        done_next      = done_reg;
        o_pair_next    = o_pair_reg;
        o_fwd_next     = o_fwd_reg;
        o_bwd_next     = o_bwd_reg;
        o_done_next    = o_done_reg;
        o_sum_next     = o_sum_reg;
        o_avg_next     = o_avg_reg;
        o_beta_next    = o_beta_reg;

        if (cfg_valid && cfg_ready)
            len_next = range_length;

        // Drop the output word once taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (!phase_reg)
                    begin
                        // Hold the first sample of the pair
                        held_next  = sample;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        // Capture the pair and start the square step
                        n_next     = eff_n;
                        pair_next  = pair_val;
                        fwd_next   = pos_reg;
                        bwd_next   = bwd_full[INDEX_W-1:0];
                        done_next  = last_pair;
                        sum_next   = sum_reg + {{(SUM_W-PAIR_W){pair_val[PAIR_W-1]}}, pair_val};
                        acc_next   = {{(ACC_W-SQ_W){1'b0}}, sq_reg};
                        mcand_next = {{(ACC_W-PAIR_W){1'b0}}, pair_mag};
                        mpl_next   = {{(MPL_W-PAIR_W){1'b0}}, pair_mag};
                        cnt_next   = SQ_STEPS - 5'd1;
                        state_next = S_SQ;
                    end
                end
            end

            S_SQ:
            begin
                acc_next   = acc_step;
                mcand_next = {mcand_reg[ACC_W-2:0], 1'b0};
                mpl_next   = {1'b0, mpl_reg[MPL_W-1:1]};
                cnt_next   = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    sq_next = acc_step[SQ_W-1:0];
                    if (done_reg)
                    begin
                        acc_next   = '0;
                        mcand_next = {{(ACC_W-SQ_W){1'b0}}, acc_step[SQ_W-1:0]};
                        mpl_next   = {{(MPL_W-LEN_W){1'b0}}, n_reg};
                        cnt_next   = NSQ_STEPS - 5'd1;
                        state_next = S_NSQ;
                    end
                    else
                    begin
                        // Advance to the next pair
                        pos_next   = pos_plus[INDEX_W-1:0];
                        phase_next = 1'b0;
                        held_next  = '0;
                        state_next = S_FIN;
                    end
                end
            end

            S_NSQ:
            begin
                acc_next   = acc_step;
                mcand_next = {mcand_reg[ACC_W-2:0], 1'b0};
                mpl_next   = {1'b0, mpl_reg[MPL_W-1:1]};
                cnt_next   = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    nsq_next   = acc_step;
                    acc_next   = '0;
                    mcand_next = {{(ACC_W-MAG_W){1'b0}}, sum_mag};
                    mpl_next   = sum_mag;
                    cnt_next   = SSQ_STEPS - 5'd1;
                    state_next = S_SSQ;
                end
            end

            S_SSQ:
            begin
                acc_next   = acc_step;
                mcand_next = {mcand_reg[ACC_W-2:0], 1'b0};
                mpl_next   = {1'b0, mpl_reg[MPL_W-1:1]};
                cnt_next   = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                    state_next = S_BETA;
            end

            S_BETA:
            begin
                // A borrow means sum^2 exceeds N*sq: clamp to zero
                beta_next  = alu_res.carry ? alu_res.value : '0;
                acc_next   = '0;
                mpl_next   = sum_mag;
                cnt_next   = DIV_STEPS - 5'd1;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                acc_next   = alu_res.carry ? alu_res.value
                                           : {{(ACC_W-REM_W){1'b0}}, rem_sh};
                mpl_next   = {mpl_reg[MPL_W-2:0], alu_res.carry};
                cnt_next   = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                    state_next = S_FIN;
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_pair_next    = pair_reg;
                    o_fwd_next     = fwd_reg;
                    o_bwd_next     = bwd_reg;
                    o_done_next    = done_reg;
                    o_sum_next     = done_reg ? sum_reg : '0;
                    o_avg_next     = done_reg ? avg_val : '0;
                    o_beta_next    = done_reg ? beta_reg : '0;
                    if (done_reg)
                    begin
                        // Clear for the next domain
                        held_next  = '0;
                        phase_next = 1'b0;
                        pos_next   = '0;
                        sum_next   = '0;
                        sq_next    = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= LEN_RESET;
            held_reg      <= '0;
            phase_reg     <= 1'b0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            held_reg      <= held_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mpl_reg    <= mpl_next;
        cnt_reg    <= cnt_next;
        nsq_reg    <= nsq_next;
        beta_reg   <= beta_next;
        n_reg      <= n_next;
        pair_reg   <= pair_next;
        fwd_reg    <= fwd_next;
        bwd_reg    <= bwd_next;
        done_reg   <= done_next;
        o_pair_reg <= o_pair_next;
        o_fwd_reg  <= o_fwd_next;
        o_bwd_reg  <= o_bwd_next;
        o_done_reg <= o_done_next;
        o_sum_reg  <= o_sum_next;
        o_avg_reg  <= o_avg_next;
        o_beta_reg <= o_beta_next;
    end

    assign out_valid      = out_valid_reg;
    assign pair_value     = o_pair_reg;
    assign forward_index  = o_fwd_reg;
    assign backward_index = o_bwd_reg;
    assign domain_done    = o_done_reg;
    assign domain_sum     = o_sum_reg;
    assign domain_average = o_avg_reg;
    assign domain_beta    = o_beta_reg;

endmodule

FILE: hdl/dds_alu.sv
// Shared add/subtract unit of the domain decimate statistics block.
// Depends on dds_pkg for widths and the result struct.

module dds_alu (
    input  logic [dds_pkg::ACC_W-1:0] op_a,
    input  logic [dds_pkg::ACC_W-1:0] op_b,
    input  logic                      sub,
    output dds_pkg::alu_res_t         res
);
    import dds_pkg::*;

    logic [ACC_W-1:0] b_eff;
    logic [ACC_W:0]   total;

    // Subtract as a plus the complement of b plus one; carry set means no borrow
    assign b_eff = sub ? ~op_b : op_b;
    assign total = {1'b0, op_a} + {1'b0, b_eff} + {{ACC_W{1'b0}}, sub};

    assign res.carry = total[ACC_W];
    assign res.value = total[ACC_W-1:0];

endmodule

FILE: tb/sv/domain_decimate_statistics_tb.sv
// Self-checking testbench for domain_decimate_statistics: drives sample words,
// predicts every pair result and the end-of-domain statistics, and checks them.
// Depends on dds_pkg and the domain_decimate_statistics RTL.

module domain_decimate_statistics_tb;

    import dds_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 100;   // margin for a closing pair to finish
    localparam int HOLD_CYCLES   = 600;   // long receiver hold-off
    localparam int RANDOM_WORDS  = 550;
    localparam int LONG_PAIRS    = 180;   // closing domain biased to the extremes

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [LEN_W-1:0]           range_length = '0;
    logic                       in_valid     = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample       = '0;
    logic                       out_valid;
    logic                       out_ready    = 1'b0;
    logic signed [PAIR_W-1:0]   pair_value;
    logic [INDEX_W-1:0]         forward_index;
    logic [INDEX_W-1:0]         backward_index;
    logic                       domain_done;
    logic signed [SUM_W-1:0]    domain_sum;
    logic signed [PAIR_W-1:0]   domain_average;
    logic [BETA_W-1:0]          domain_beta;

    // One expected output word
    typedef struct {
        logic signed [PAIR_W-1:0] value;
        logic [INDEX_W-1:0]       fwd;
        logic [INDEX_W-1:0]       bwd;
        logic                     done;
        logic signed [SUM_W-1:0]  sum;
        logic signed [PAIR_W-1:0] avg;
        logic [BETA_W-1:0]        beta;
    } pair_result_t;

    pair_result_t        pair_results_due[$];   // predicted words, oldest first
    logic [SAMPLE_W-1:0] samples_queued[$];     // words waiting for the driver

    // Predictor copy of the block state and its length register
    logic [LEN_W-1:0] len_reg    = LEN_RESET;
    longint           held_smp   = 0;
    bit               pair_open  = 1'b0;
    int               pairs_done = 0;
    longint           sum_acc    = 0;
    longint           sq_acc     = 0;

    // Flow control knobs, written by the stimulus at the falling edge
    int send_idle_pct = 10;
    int recv_idle_pct = 74;
    int hold_requests = 0;

    // Owned by the receiver process
    int hold_served = 0;
    int hold_left   = 0;

    int mismatches  = 0;
    int cycle_count = 0;

    domain_decimate_statistics i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .range_length   (range_length),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pair_value     (pair_value),
        .forward_index  (forward_index),
        .backward_index (backward_index),
        .domain_done    (domain_done),
        .domain_sum     (domain_sum),
        .domain_average (domain_average),
        .domain_beta    (domain_beta)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Fold one accepted sample into the predicted state. The second sample of a
    // pair yields a word; the pair that reaches position N-1 or beyond closes the
    // domain, carries the statistics and clears the state.
    task automatic fold_sample(input logic signed [SAMPLE_W-1:0] s);
        longint       n;
        longint       pos;
        longint       v;
        longint       back;
        longint       nsq;
        longint       ssq;
        longint       avg;
        pair_result_t r;
        if (!pair_open)
        begin
            held_smp  = s;
            pair_open = 1'b1;
            return;
        end
        // Clamp the length: zero acts as one, anything past the maximum saturates
        if (len_reg == '0)
            n = 1;
        else if (len_reg > MAX_PAIRS)
            n = MAX_PAIRS;
        else
            n = len_reg;
        pos     = pairs_done;
        v       = held_smp + s;
        sum_acc = sum_acc + v;
        sq_acc  = sq_acc + v * v;
        back    = n - 1 - pos;   // wraps to 12 bits if N shrank mid-domain
        r.value = v[PAIR_W-1:0];
        r.fwd   = pos[INDEX_W-1:0];
        r.bwd   = back[INDEX_W-1:0];
        r.done  = (pos + 1 >= n);
        r.sum   = '0;
        r.avg   = '0;
        r.beta  = '0;
        if (r.done)
        begin
            nsq   = n * sq_acc;
            ssq   = sum_acc * sum_acc;
            avg   = sum_acc / n;           // truncates toward zero
            r.sum = sum_acc[SUM_W-1:0];
            r.avg = avg[PAIR_W-1:0];       // may wrap after a mid-domain change
            // Clip a negative beta to zero
            if (nsq > ssq)
            begin
                nsq    = nsq - ssq;
                r.beta = nsq[BETA_W-1:0];
            end
            pairs_done = 0;
            sum_acc    = 0;
            sq_acc     = 0;
        end
        else
        begin
            pairs_done = (pairs_done + 1) % (1 << INDEX_W);
        end
        held_smp  = 0;
        pair_open = 1'b0;
        pair_results_due.push_back(r);
    endtask

    task automatic check_field(input string what, input logic [63:0] want, got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
        end
    endtask

    // Driver: advance to the next queued word once the current one is taken,
    // or drop valid for a random idle cycle. Hold valid and the word otherwise.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                fold_sample(sample);
            if (!in_valid || in_ready)
            begin
                if (samples_queued.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    sample   <= samples_queued.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver and checker: compare each taken word with the oldest prediction,
    // then pick out_ready for the next cycle. A hold-off request keeps ready low
    // for a long stretch so the block fills up and stalls its input.
    always @(posedge clk)
    begin
        pair_result_t r;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pair_results_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none, actual pair_value %0d",
                             $time, pair_value);
                end
                else
                begin
                    r = pair_results_due.pop_front();
                    check_field("pair_value",     64'(r.value), 64'(pair_value));
                    check_field("forward_index",  64'(r.fwd),   64'(forward_index));
                    check_field("backward_index", 64'(r.bwd),   64'(backward_index));
                    check_field("domain_done",    64'(r.done),  64'(domain_done));
                    check_field("domain_sum",     64'(r.sum),   64'(domain_sum));
                    check_field("domain_average", 64'(r.avg),   64'(domain_average));
                    check_field("domain_beta",    64'(r.beta),  64'(domain_beta));
                end
            end
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Wait until every queued word is taken and every predicted word has come
    // back, then give the block time to finish any work that yields no word.
    task automatic settle();
        while (samples_queued.size() != 0 || in_valid || pair_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write range_length through the config channel; the block must be idle.
    task automatic write_length(input logic [LEN_W-1:0] value);
        @(posedge clk);
        cfg_valid    <= 1'b1;
        range_length <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        len_reg = value;
        @(negedge clk);
    endtask

    task automatic offer_pair(input logic [SAMPLE_W-1:0] a, b);
        samples_queued.push_back(a);
        samples_queued.push_back(b);
    endtask

    // Mostly random words, with a good share of the extremes and zero
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int               pick;
        int               n_eff;
        int               seg_words;
        int               rnd_words;
        bit               first_seg;
        logic [LEN_W-1:0] len_pick;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset length of 64, largest and smallest pair values
        offer_pair(16'h7fff, 16'h7fff);
        offer_pair(16'h8000, 16'h8000);
        // Length zero acts as one; change it mid-domain so the next pair closes
        settle();
        write_length('0);
        offer_pair(16'h0000, 16'hffff);
        offer_pair(16'hffff, 16'h0000);
        // Lengths past the maximum saturate; then shrink to one mid-domain so the
        // average wraps and beta would go negative
        settle();
        write_length(LEN_W'(8191));
        offer_pair(16'h7fff, 16'h7fff);
        offer_pair(16'h7fff, 16'h7fff);
        settle();
        write_length(LEN_W'(4097));
        offer_pair(16'h7fff, 16'h7fff);
        settle();
        write_length(LEN_W'(1));
        offer_pair(16'h7fff, 16'h7fff);
        // A short complete domain with mixed signs
        settle();
        write_length(LEN_W'(3));
        offer_pair(16'h8000, 16'h7fff);
        offer_pair(16'h0001, 16'hffff);
        offer_pair(pick_sample(), pick_sample());

        // Random segments: mostly whole domains at small lengths, some broken
        // tails and some partial passes at oversized lengths, so the next
        // length write often lands mid-domain.
        rnd_words = 0;
        first_seg = 1'b1;
        while (rnd_words < RANDOM_WORDS)
        begin
            settle();
            if (rnd_words < RANDOM_WORDS / 3)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 74;
            end
            else if (rnd_words < 2 * RANDOM_WORDS / 3)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 8)
                len_pick = '0;
            else if (pick < 14)
                len_pick = LEN_W'($urandom_range(4097, 8191));
            else if (pick < 70)
                len_pick = LEN_W'($urandom_range(1, 8));
            else if (pick < 92)
                len_pick = LEN_W'($urandom_range(9, 40));
            else
                len_pick = LEN_W'($urandom_range(41, 128));
            write_length(len_pick);
            if (len_pick > MAX_PAIRS)
            begin
                seg_words = $urandom_range(1, 12);
            end
            else
            begin
                n_eff     = (len_pick == '0) ? 1 : int'(len_pick);
                seg_words = 2 * n_eff * $urandom_range(1, 3);
                if ($urandom_range(4) == 0)
                    seg_words += $urandom_range(1, 2 * n_eff);
            end
            // Stall the output for a long stretch while words keep coming
            if (first_seg)
            begin
                hold_requests++;
                seg_words += 40;
                first_seg = 1'b0;
            end
            repeat (seg_words) samples_queued.push_back(pick_sample());
            rnd_words += seg_words;
        end

        // Close any open domain at length one, then run one long domain biased
        // to the extremes
        settle();
        write_length(LEN_W'(1));
        if (pair_open)
            samples_queued.push_back(pick_sample());
        else if (pairs_done != 0)
            offer_pair(pick_sample(), pick_sample());
        settle();
        write_length(LEN_W'(LONG_PAIRS));
        repeat (2 * LONG_PAIRS)
        begin
            if ($urandom_range(3) == 0)
                samples_queued.push_back(pick_sample());
            else
                samples_queued.push_back($urandom_range(1) ? 16'h7fff : 16'h8000);
        end
        settle();

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
